[hw/rtl/elevator_fifo_controller_macros.svh]
// Assertion macros shared by the elevator controller RTL.
`ifndef ELEVATOR_FIFO_CONTROLLER_MACROS_SVH
`define ELEVATOR_FIFO_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EFC_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define EFC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/efc_pkg.sv]
// Types and constants shared by the elevator controller modules.
package efc_pkg;

   localparam int FLOOR_W  = 7;
   localparam int TIMER_W  = 16;
   localparam int PEND_W   = 8;
   localparam int CSR_IDX_W = 4;

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_TICKS      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_OPEN_TICKS = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBST_HOLD_TICKS = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_CLOSE_TICKS = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAULT_TICKS     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAME_FLOOR_TICKS = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWEST_FLOOR    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGHEST_FLOOR   = 4'd7;

   // Register reset values
   localparam logic [TIMER_W-1:0] RST_MOVE_TICKS       = 16'd3000;
   localparam logic [TIMER_W-1:0] RST_DOOR_OPEN_TICKS  = 16'd3000;
   localparam logic [TIMER_W-1:0] RST_OBST_HOLD_TICKS  = 16'd8900;
   localparam logic [TIMER_W-1:0] RST_DOOR_CLOSE_TICKS = 16'd2000;
   localparam logic [TIMER_W-1:0] RST_FAULT_TICKS      = 16'd2000;
   localparam logic [TIMER_W-1:0] RST_SAME_FLOOR_TICKS = 16'd2000;
   localparam logic [FLOOR_W-1:0] RST_LOWEST_FLOOR     = 7'd0;
   localparam logic [FLOOR_W-1:0] RST_HIGHEST_FLOOR    = 7'd99;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_UP    = 3'd1,
      ST_DOWN  = 3'd2,
      ST_OPEN  = 3'd3,
      ST_OBST  = 3'd4,
      ST_CLOSE = 3'd5,
      ST_FAULT = 3'd6
   } car_state_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_UP    = 3'd1,
      CMD_DOWN  = 3'd2,
      CMD_OPEN  = 3'd3,
      CMD_OBST  = 3'd4,
      CMD_CLOSE = 3'd5
   } motor_cmd_type;

   typedef enum logic [1:0] {
      RS_NONE   = 2'd0,
      RS_ACCEPT = 2'd1,
      RS_RANGE  = 2'd2,
      RS_FULL   = 2'd3
   } req_status_type;

   typedef struct packed {
      logic               mode;
      logic [FLOOR_W-1:0] floor_request;
      logic               emergency_button;
      logic               obstacle_sensor;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         car_state;
      logic [FLOOR_W-1:0] car_floor;
      logic [2:0]         motor_command;
      logic [1:0]         request_status;
      logic [PEND_W-1:0]  pending_count;
   } rsp_word_type;

   typedef struct packed {
      logic [TIMER_W-1:0] move_ticks;
      logic [TIMER_W-1:0] door_open_ticks;
      logic [TIMER_W-1:0] obstacle_hold_ticks;
      logic [TIMER_W-1:0] door_close_ticks;
      logic [TIMER_W-1:0] fault_ticks;
      logic [TIMER_W-1:0] same_floor_ticks;
      logic [FLOOR_W-1:0] lowest_floor;
      logic [FLOOR_W-1:0] highest_floor;
   } cfg_type;

   // Classified word handed from front to back
   typedef struct packed {
      logic               is_req;
      logic               in_range;
      logic [FLOOR_W-1:0] floor;
      logic               emergency;
      logic               obstacle;
   } cmd_word_type;

   // Queue status seen by the front
   typedef struct packed {
      logic full;
      logic valid;
   } cmdq_status_type;

endpackage

[hw/rtl/efc_csr.sv]
// Configuration register file of the elevator controller.
module efc_csr import efc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIMER_W-1:0]   csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MOVE_TICKS:       cfg_in.move_ticks          = csr_wdata;
            CSR_DOOR_OPEN_TICKS:  cfg_in.door_open_ticks     = csr_wdata;
            CSR_OBST_HOLD_TICKS:  cfg_in.obstacle_hold_ticks = csr_wdata;
            CSR_DOOR_CLOSE_TICKS: cfg_in.door_close_ticks    = csr_wdata;
            CSR_FAULT_TICKS:      cfg_in.fault_ticks         = csr_wdata;
            CSR_SAME_FLOOR_TICKS: cfg_in.same_floor_ticks    = csr_wdata;
            CSR_LOWEST_FLOOR:     cfg_in.lowest_floor  = csr_wdata[FLOOR_W-1:0];
            CSR_HIGHEST_FLOOR:    cfg_in.highest_floor = csr_wdata[FLOOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_ticks          <= RST_MOVE_TICKS;
         cfg_ff.door_open_ticks     <= RST_DOOR_OPEN_TICKS;
         cfg_ff.obstacle_hold_ticks <= RST_OBST_HOLD_TICKS;
         cfg_ff.door_close_ticks    <= RST_DOOR_CLOSE_TICKS;
         cfg_ff.fault_ticks         <= RST_FAULT_TICKS;
         cfg_ff.same_floor_ticks    <= RST_SAME_FLOOR_TICKS;
         cfg_ff.lowest_floor        <= RST_LOWEST_FLOOR;
         cfg_ff.highest_floor       <= RST_HIGHEST_FLOOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/efc_front.sv]
// Front end: accepts input words and classifies them for the back end.
module efc_front import efc_pkg::*; (
   input  logic            req_valid,
   output logic            req_stall,
   input  req_word_type    req_word,
   input  cfg_type         cfg,
   input  cmdq_status_type q_status,
   output logic            push,
   output cmd_word_type    push_word
);

   logic in_range;

   // Stall only when the command queue has no room
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // Range check against the configured floor window
   assign in_range = (req_word.floor_request >= cfg.lowest_floor) &&
                     (req_word.floor_request <= cfg.highest_floor);

   always_comb begin
      push_word.is_req    = req_word.mode;
      push_word.in_range  = in_range;
      push_word.floor     = req_word.floor_request;
      push_word.emergency = req_word.emergency_button;
      push_word.obstacle  = req_word.obstacle_sensor;
   end

endmodule

[hw/rtl/efc_cmdq.sv]
// Short command queue decoupling the front end from the back end.
module efc_cmdq import efc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_word_type    push_word,
   input  logic            pop,
   output cmdq_status_type q_status,
   output cmd_word_type    pop_word
);

   cmd_word_type            slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign q_status.valid = (count_ff != '0);
   assign pop_word       = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

[hw/rtl/efc_back.sv]
// Back end: request ring, car state machine and result register.
module efc_back import efc_pkg::*; #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  cmdq_status_type q_status,
   input  cmd_word_type    q_word,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_word_type    rsp_word
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Request ring memory
   logic [FLOOR_W-1:0]  ring_mem [QUEUE_DEPTH];
   logic [FLOOR_W-1:0]  rd_data_ff;
   logic                byp_ff;
   logic [FLOOR_W-1:0]  byp_data_ff;
   logic [FLOOR_W-1:0]  head_val;
   logic                wr_en;

   car_state_type       state_ff, state_in;
   logic [FLOOR_W-1:0]  floor_ff, floor_in;
   logic [FLOOR_W-1:0]  target_ff, target_in;
   logic [TIMER_W-1:0]  dwell_ff, dwell_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   logic                fire;
   logic                expired;
   logic                going_up;
   logic [TIMER_W-1:0]  dwell_dec;
   motor_cmd_type       cmd;
   req_status_type      status;

   // Take a word when the result register is free or being drained
   assign fire      = q_status.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop       = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Head of the ring, with bypass of a write to the address just read
   assign head_val  = byp_ff ? byp_data_ff : rd_data_ff;

   assign expired   = (dwell_ff <= TIMER_W'(1));
   assign dwell_dec = dwell_ff - TIMER_W'(1);
   assign going_up  = (state_ff == ST_UP);

   // Next state, ring update and result
   always_comb begin
      state_in  = state_ff;
      floor_in  = floor_ff;
      target_in = target_ff;
      dwell_in  = dwell_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      fill_in   = fill_ff;
      wr_en     = 1'b0;
      cmd       = CMD_NONE;
      status    = RS_NONE;
      if (fire) begin
         if (q_word.is_req) begin
            // floor request: range check, then room check
            if (!q_word.in_range) begin
               status = RS_RANGE;
            end else if (fill_ff == CNT_W'(QUEUE_DEPTH)) begin
               status = RS_FULL;
            end else begin
               wr_en   = 1'b1;
               tail_in = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               fill_in = fill_ff + 1'b1;
               status  = RS_ACCEPT;
            end
         end else begin
            unique case (state_ff) inside
               ST_IDLE: begin
                  if (dwell_ff != '0) begin
                     dwell_in = dwell_dec;
                  end else if (fill_ff != '0) begin
                     target_in = head_val;
                     head_in   = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                     fill_in   = fill_ff - 1'b1;
                     if (head_val > floor_ff) begin
                        state_in = ST_UP;
                        dwell_in = cfg.move_ticks;
                        cmd      = CMD_UP;
                     end else if (head_val < floor_ff) begin
                        state_in = ST_DOWN;
                        dwell_in = cfg.move_ticks;
                        cmd      = CMD_DOWN;
                     end else begin
                        // same floor: hold in idle
                        dwell_in = cfg.same_floor_ticks;
                     end
                  end
               end
               ST_UP, ST_DOWN: begin
                  if (!expired) begin
                     dwell_in = dwell_dec;
                  end else begin
                     if (going_up && (floor_ff < target_ff)) begin
                        floor_in = floor_ff + FLOOR_W'(1);
                     end else if (!going_up && (floor_ff > target_ff)) begin
                        floor_in = floor_ff - FLOOR_W'(1);
                     end
                     if (q_word.emergency) begin
                        state_in = ST_FAULT;
                        dwell_in = cfg.fault_ticks;
                     end else if (floor_in == target_ff) begin
                        state_in = ST_OPEN;
                        dwell_in = cfg.door_open_ticks;
                        cmd      = CMD_OPEN;
                     end else begin
                        dwell_in = cfg.move_ticks;
                     end
                  end
               end
               ST_OPEN, ST_OBST: begin
                  if (!expired) begin
                     dwell_in = dwell_dec;
                  end else if ((state_ff == ST_OPEN) && q_word.obstacle) begin
                     state_in = ST_OBST;
                     dwell_in = cfg.obstacle_hold_ticks;
                     cmd      = CMD_OBST;
                  end else if (q_word.emergency) begin
                     // emergency on closing entry
                     state_in = ST_FAULT;
                     dwell_in = cfg.fault_ticks;
                  end else begin
                     state_in = ST_CLOSE;
                     dwell_in = cfg.door_close_ticks;
                     cmd      = CMD_CLOSE;
                  end
               end
               ST_CLOSE, ST_FAULT: begin
                  if (!expired) begin
                     dwell_in = dwell_dec;
                  end else begin
                     state_in = ST_IDLE;
                     dwell_in = '0;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
                  dwell_in = '0;
               end
            endcase
         end
      end

      rsp_word_in.car_state      = state_in;
      rsp_word_in.car_floor      = floor_in;
      rsp_word_in.motor_command  = cmd;
      rsp_word_in.request_status = status;
      rsp_word_in.pending_count  = PEND_W'(fill_in);

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         floor_ff     <= '0;
         target_ff    <= '0;
         dwell_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         floor_ff     <= floor_in;
         target_ff    <= target_in;
         dwell_ff     <= dwell_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         byp_ff       <= wr_en && (tail_ff == head_in);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Ring write at tail, registered read of the next head
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[tail_ff] <= q_word.floor;
      end
      rd_data_ff  <= ring_mem[head_in];
      byp_data_ff <= q_word.floor;
   end

endmodule

[hw/rtl/elevator_fifo_controller.sv]
// Elevator controller top level: floor request ring queue and car state machine.
//
// Input channel (req_*): one word per accepted item. mode 1 pushes floor_request
// into the request ring, mode 0 is a tick that advances the car state machine.
// Result channel (rsp_*): exactly one result word per input word, in order.
// Register port (csr_*): eight registers; the user must write them only while the block is idle, which is not enforced.
//
// Path: an accepted word goes through the command queue into the result register
// behind rsp_valid. Throughput: one word per cycle while rsp_stall is low, set by
// the state update in the back end; the ring head is kept prefetched from the ring memory.
// A two-word command queue sits between front and back end; when the receiver
// stalls, the result register holds, the queue fills and req_stall rises.
// Reset (synchronous) loads the register defaults, empties both queues and
// puts the car idle at floor zero. The ring memory itself is not cleared.
`include "elevator_fifo_controller_macros.svh"

module elevator_fifo_controller import efc_pkg::*; #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_word_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_word_type         rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIMER_W-1:0]   csr_wdata
);

   cfg_type         cfg;
   cmdq_status_type q_status;
   logic            push;
   logic            pop;
   cmd_word_type    push_word;
   cmd_word_type    q_word;

   efc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   efc_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cfg       (cfg),
      .q_status  (q_status),
      .push      (push),
      .push_word (push_word)
   );

   efc_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .q_status  (q_status),
      .pop_word  (q_word)
   );

   efc_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_status  (q_status),
      .q_word    (q_word),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Checks
   `EFC_ASSERT_IMPLY(a_up_cmd_state, clock, reset,
      rsp_valid && (rsp_word.motor_command == CMD_UP), rsp_word.car_state == ST_UP,
      "up command without up state")
   `EFC_ASSERT_IMPLY(a_down_cmd_state, clock, reset,
      rsp_valid && (rsp_word.motor_command == CMD_DOWN), rsp_word.car_state == ST_DOWN,
      "down command without down state")
   `EFC_ASSERT_IMPLY(a_req_no_cmd, clock, reset,
      rsp_valid && (rsp_word.request_status != RS_NONE),
      rsp_word.motor_command == CMD_NONE,
      "request word carried a motor command")
   `EFC_ASSERT_NEXT(a_accept_queued, clock, reset,
      req_valid && !req_stall && !q_status.valid, q_status.valid,
      "accepted word did not reach the command queue")

endmodule

[tb/sv/elevator_fifo_controller_tb.sv]
// Self-checking testbench for the elevator controller: request ring, car FSM and registers.
`timescale 1ns / 1ps

module elevator_fifo_controller_tb;
   import efc_pkg::*;

   localparam int RING_DEPTH   = 128;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PRINT_LIMIT  = 40;
   localparam int HOLD_OFF_LEN = 60;

   // DUT connections
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_word_type         req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_word_type         rsp_word;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIMER_W-1:0]   csr_wdata = '0;

   // Car model state and register copy
   cfg_type             cfg_q;
   car_state_type       car_q;
   logic [FLOOR_W-1:0]  floor_q;
   logic [FLOOR_W-1:0]  target_q;
   logic [TIMER_W-1:0]  dwell_q;
   logic [FLOOR_W-1:0]  waiting_floors[$];
   rsp_word_type        expected_car_words[$];

   // Traffic shaping
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   int unsigned rsp_hold_cycles = 0;
   int unsigned rsp_stall_left = 0;
   int unsigned quiet_cycles = 0;

   // Run statistics
   int unsigned mismatch_count = 0;
   int unsigned words_sent = 0;
   int unsigned calls_sent = 0;
   int unsigned results_checked = 0;
   int unsigned reg_writes = 0;
   int unsigned status_seen[4];
   int unsigned door_opens = 0;
   int unsigned obstacle_holds = 0;
   int unsigned fault_entries = 0;

   elevator_fifo_controller #(
      .QUEUE_DEPTH(RING_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- car model

   // Counts the dwell timer down; true when the wait of this state ends now
   function automatic bit dwell_done();
      if (dwell_q > 1) begin
         dwell_q--;
         return 1'b0;
      end
      dwell_q = '0;
      return 1'b1;
   endfunction

   function automatic motor_cmd_type enter_fault();
      car_q   = ST_FAULT;
      dwell_q = cfg_q.fault_ticks;
      return CMD_NONE;
   endfunction

   // Door closing entry, emergency wins over the close command
   function automatic motor_cmd_type close_or_fault(input logic emerg);
      if (emerg)
         return enter_fault();
      car_q   = ST_CLOSE;
      dwell_q = cfg_q.door_close_ticks;
      return CMD_CLOSE;
   endfunction

   // One floor step when the move period ends, then emergency and arrival
   function automatic motor_cmd_type floor_step(input bit going_up, input logic emerg);
      if (!dwell_done())
         return CMD_NONE;
      if (going_up && floor_q < target_q)
         floor_q++;
      else if (!going_up && floor_q > target_q)
         floor_q--;
      if (emerg)
         return enter_fault();
      if (floor_q == target_q) begin
         car_q   = ST_OPEN;
         dwell_q = cfg_q.door_open_ticks;
         return CMD_OPEN;
      end
      dwell_q = cfg_q.move_ticks;
      return CMD_NONE;
   endfunction

   function automatic motor_cmd_type car_tick(input logic emerg, input logic obst);
      case (car_q)
         ST_IDLE: begin
            if (dwell_q > 0) begin
               dwell_q--;
               return CMD_NONE;
            end
            if (waiting_floors.size() == 0)
               return CMD_NONE;
            target_q = waiting_floors.pop_front();
            if (target_q > floor_q) begin
               car_q   = ST_UP;
               dwell_q = cfg_q.move_ticks;
               return CMD_UP;
            end
            if (target_q < floor_q) begin
               car_q   = ST_DOWN;
               dwell_q = cfg_q.move_ticks;
               return CMD_DOWN;
            end
            // same floor: stay idle and hold
            dwell_q = cfg_q.same_floor_ticks;
            return CMD_NONE;
         end
         ST_UP:   return floor_step(1'b1, emerg);
         ST_DOWN: return floor_step(1'b0, emerg);
         ST_OPEN: begin
            if (!dwell_done())
               return CMD_NONE;
            if (obst) begin
               car_q   = ST_OBST;
               dwell_q = cfg_q.obstacle_hold_ticks;
               return CMD_OBST;
            end
            return close_or_fault(emerg);
         end
         ST_OBST: begin
            if (!dwell_done())
               return CMD_NONE;
            return close_or_fault(emerg);
         end
         ST_CLOSE, ST_FAULT: begin
            if (dwell_done())
               car_q = ST_IDLE;
            return CMD_NONE;
         end
         default: begin
            car_q   = ST_IDLE;
            dwell_q = '0;
            return CMD_NONE;
         end
      endcase
   endfunction

   // Expected result word for one accepted input word; updates the model
   function automatic rsp_word_type next_car_word(input req_word_type w);
      rsp_word_type   r;
      motor_cmd_type  cmd;
      req_status_type status;
      cmd    = CMD_NONE;
      status = RS_NONE;
      if (w.mode) begin
         if (w.floor_request < cfg_q.lowest_floor || w.floor_request > cfg_q.highest_floor)
            status = RS_RANGE;
         else if (waiting_floors.size() >= RING_DEPTH)
            status = RS_FULL;
         else begin
            waiting_floors.push_back(w.floor_request);
            status = RS_ACCEPT;
         end
      end else begin
         cmd = car_tick(w.emergency_button, w.obstacle_sensor);
         if (car_q == ST_FAULT && dwell_q == cfg_q.fault_ticks && cmd == CMD_NONE)
            fault_entries++;
      end
      status_seen[status]++;
      if (cmd == CMD_OPEN)
         door_opens++;
      if (cmd == CMD_OBST)
         obstacle_holds++;
      r.car_state      = car_q;
      r.car_floor      = floor_q;
      r.motor_command  = cmd;
      r.request_status = status;
      r.pending_count  = PEND_W'(waiting_floors.size());
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic req_word_type tick_word(input logic emerg, input logic obst);
      req_word_type w;
      w.mode             = 1'b0;
      w.floor_request    = FLOOR_W'($urandom_range(0, 127));
      w.emergency_button = emerg;
      w.obstacle_sensor  = obst;
      return w;
   endfunction

   function automatic req_word_type call_word(input int unsigned fl);
      req_word_type w;
      w.mode             = 1'b1;
      w.floor_request    = FLOOR_W'(fl);
      w.emergency_button = $urandom_range(0, 1);
      w.obstacle_sensor  = $urandom_range(0, 1);
      return w;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!req_idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // A floor other than the current one
   function automatic int unsigned other_floor();
      int unsigned f;
      do
         f = $urandom_range(0, 127);
      while (f == floor_q);
      return f;
   endfunction

   // Offers one word until it is taken, records its result, then maybe idles
   task automatic send_word(input req_word_type w);
      int unsigned gap;
      req_valid <= 1'b1;
      req_word  <= w;
      do
         @(posedge clock);
      while (req_stall);
      expected_car_words.push_back(next_car_word(w));
      words_sent++;
      if (w.mode)
         calls_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic ticks_until(input car_state_type goal, input logic emerg, input logic obst);
      int unsigned n;
      n = 0;
      while (car_q != goal && n < 200000) begin
         send_word(tick_word(emerg, obst));
         n++;
      end
   endtask

   // Ticks until the car is idle, unheld and has no floor waiting
   task automatic settle_car();
      while (!(car_q == ST_IDLE && dwell_q == 0 && waiting_floors.size() == 0))
         send_word(tick_word(1'b0, 1'b0));
   endtask

   // Register write once every result has come back
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIMER_W-1:0] val);
      req_valid <= 1'b0;
      while (expected_car_words.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      reg_writes++;
      case (idx)
         CSR_MOVE_TICKS:       cfg_q.move_ticks = val;
         CSR_DOOR_OPEN_TICKS:  cfg_q.door_open_ticks = val;
         CSR_OBST_HOLD_TICKS:  cfg_q.obstacle_hold_ticks = val;
         CSR_DOOR_CLOSE_TICKS: cfg_q.door_close_ticks = val;
         CSR_FAULT_TICKS:      cfg_q.fault_ticks = val;
         CSR_SAME_FLOOR_TICKS: cfg_q.same_floor_ticks = val;
         CSR_LOWEST_FLOOR:     cfg_q.lowest_floor = val[FLOOR_W-1:0];
         CSR_HIGHEST_FLOOR:    cfg_q.highest_floor = val[FLOOR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_timers(input int unsigned mv, input int unsigned dopen,
                             input int unsigned obst, input int unsigned dclose,
                             input int unsigned flt, input int unsigned same);
      write_reg(CSR_MOVE_TICKS, TIMER_W'(mv));
      write_reg(CSR_DOOR_OPEN_TICKS, TIMER_W'(dopen));
      write_reg(CSR_OBST_HOLD_TICKS, TIMER_W'(obst));
      write_reg(CSR_DOOR_CLOSE_TICKS, TIMER_W'(dclose));
      write_reg(CSR_FAULT_TICKS, TIMER_W'(flt));
      write_reg(CSR_SAME_FLOOR_TICKS, TIMER_W'(same));
   endtask

   task automatic set_range(input int unsigned lo, input int unsigned hi);
      write_reg(CSR_LOWEST_FLOOR, TIMER_W'(lo));
      write_reg(CSR_HIGHEST_FLOOR, TIMER_W'(hi));
   endtask

   // ---------------------------------------------------------------- tests

   // Reset values: range 0..99 and the long default timers on one short trip
   task automatic test_reset_values();
      send_word(tick_word(1'b0, 1'b0));
      send_word(call_word(1));
      send_word(call_word(100));
      send_word(call_word(127));
      send_word(call_word(99));
      send_word(call_word(0));
      send_word(tick_word(1'b0, 1'b0));
      ticks_until(ST_OPEN, 1'b0, 1'b0);
      ticks_until(ST_IDLE, 1'b0, 1'b0);
   endtask

   task automatic test_register_writes();
      set_timers(2, 2, 3, 2, 3, 2);
      set_range(0, 127);
      settle_car();
   endtask

   // Up and down trips, same-floor hold and the obstacle extension
   task automatic test_travel_and_doors();
      send_word(call_word(floor_q));
      send_word(tick_word(1'b0, 1'b0));
      send_word(call_word(other_floor()));
      send_word(call_word(0));
      send_word(call_word(127));
      settle_car();
      send_word(call_word(other_floor()));
      ticks_until(ST_OPEN, 1'b0, 1'b0);
      ticks_until(ST_OBST, 1'b0, 1'b1);
      ticks_until(ST_IDLE, 1'b0, 1'b0);
   endtask

   // Emergency on a floor step, on leaving the open door and the obstacle hold
   task automatic test_emergency_stops();
      send_word(call_word(other_floor()));
      send_word(tick_word(1'b0, 1'b0));
      ticks_until(ST_FAULT, 1'b1, 1'b0);
      settle_car();
      send_word(call_word(other_floor()));
      ticks_until(ST_OPEN, 1'b0, 1'b0);
      ticks_until(ST_FAULT, 1'b1, 1'b0);
      settle_car();
      send_word(call_word(other_floor()));
      ticks_until(ST_OPEN, 1'b0, 1'b0);
      ticks_until(ST_OBST, 1'b0, 1'b1);
      ticks_until(ST_FAULT, 1'b1, 1'b0);
      settle_car();
   endtask

   // Timers written as zero, which all but the same-floor hold treat like one; then the smallest legal value
   task automatic test_zero_timers();
      set_timers(0, 0, 0, 0, 0, 0);
      send_word(call_word(floor_q));
      send_word(call_word(other_floor()));
      send_word(call_word(other_floor()));
      repeat (4) send_word(tick_word(1'b0, 1'b1));
      settle_car();
      set_timers(1, 1, 1, 1, 1, 1);
      send_word(call_word(other_floor()));
      ticks_until(ST_OPEN, 1'b0, 1'b0);
      ticks_until(ST_OBST, 1'b0, 1'b1);
      settle_car();
   endtask

   task automatic test_range_limits();
      set_range(127, 0);
      send_word(call_word(0));
      send_word(call_word(127));
      send_word(call_word(64));
      set_range(50, 50);
      send_word(call_word(49));
      send_word(call_word(50));
      send_word(call_word(51));
      set_range(0, 127);
      settle_car();
   endtask

   // Fill the ring past its depth with no ticks, then drain it
   task automatic test_queue_full();
      repeat (RING_DEPTH + 3) send_word(call_word($urandom_range(0, 127)));
      settle_car();
   endtask

   // Receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      req_idle_on     = 1'b0;
      rsp_hold_cycles = HOLD_OFF_LEN;
      repeat (24) begin
         if ($urandom_range(0, 3) == 0)
            send_word(call_word($urandom_range(0, 127)));
         else
            send_word(tick_word(1'b0, $urandom_range(0, 1)));
      end
      req_idle_on = 1'b1;
   endtask

   // Random traffic over several register settings
   task automatic test_random_traffic();
      int unsigned lo, hi, fl, span;
      for (int p = 0; p < 8; p++) begin
         span = (p == 3) ? 40 : 4;
         set_timers($urandom_range(1, span), $urandom_range(1, span),
                    $urandom_range(1, span), $urandom_range(1, span),
                    $urandom_range(1, span), $urandom_range(1, span));
         if (p == 2) begin
            lo = $urandom_range(0, 127);
            hi = (lo + $urandom_range(0, 15) > 127) ? 127 : lo + $urandom_range(0, 15);
         end else if (p == 5) begin
            lo = $urandom_range(64, 127);
            hi = $urandom_range(0, 63);
         end else begin
            lo = $urandom_range(0, 10);
            hi = $urandom_range(117, 127);
         end
         set_range(lo, hi);
         req_idle_on = (p % 2 == 0);
         rsp_idle_on = (p % 3 != 0);
         repeat (200) begin
            if ($urandom_range(0, 99) < 25) begin
               if (lo <= hi && $urandom_range(0, 99) < 85)
                  fl = $urandom_range(lo, hi);
               else
                  fl = $urandom_range(0, 127);
               send_word(call_word(fl));
            end else begin
               send_word(tick_word($urandom_range(0, 39) == 0, $urandom_range(0, 2) == 0));
            end
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      set_timers(1, 2, 2, 1, 2, 1);
      set_range(0, 127);
      settle_car();
   endtask

   // Largest move period over one floor
   task automatic test_longest_move();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      set_timers(65535, 1, 1, 1, 1, 1);
      send_word(call_word((floor_q == 127) ? 126 : floor_q + 1));
      ticks_until(ST_OPEN, 1'b0, 1'b0);
      write_reg(CSR_MOVE_TICKS, TIMER_W'(2));
      settle_car();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] result %0d %s: got %0h, expected %0h",
                  $time, results_checked, what, got, want);
   endtask

   task automatic check_car_word(input rsp_word_type got);
      rsp_word_type want;
      if (expected_car_words.size() == 0) begin
         report_mismatch("word with none outstanding", got, '0);
         return;
      end
      want = expected_car_words.pop_front();
      results_checked++;
      if (got.car_state !== want.car_state)
         report_mismatch("car_state", got.car_state, want.car_state);
      if (got.car_floor !== want.car_floor)
         report_mismatch("car_floor", got.car_floor, want.car_floor);
      if (got.motor_command !== want.motor_command)
         report_mismatch("motor_command", got.motor_command, want.motor_command);
      if (got.request_status !== want.request_status)
         report_mismatch("request_status", got.request_status, want.request_status);
      if (got.pending_count !== want.pending_count)
         report_mismatch("pending_count", got.pending_count, want.pending_count);
   endtask

   // Result side: check accepted words, then pick next cycle's stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_car_word(rsp_word);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 99) >= 70) begin
            rsp_stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(7, 24);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
                  $time, QUIET_LIMIT, expected_car_words.size());
         $display("elevator_fifo_controller: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      cfg_q.move_ticks          = RST_MOVE_TICKS;
      cfg_q.door_open_ticks     = RST_DOOR_OPEN_TICKS;
      cfg_q.obstacle_hold_ticks = RST_OBST_HOLD_TICKS;
      cfg_q.door_close_ticks    = RST_DOOR_CLOSE_TICKS;
      cfg_q.fault_ticks         = RST_FAULT_TICKS;
      cfg_q.same_floor_ticks    = RST_SAME_FLOOR_TICKS;
      cfg_q.lowest_floor        = RST_LOWEST_FLOOR;
      cfg_q.highest_floor       = RST_HIGHEST_FLOOR;
      car_q    = ST_IDLE;
      floor_q  = '0;
      target_q = '0;
      dwell_q  = '0;
      foreach (status_seen[i])
         status_seen[i] = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_register_writes();
      test_travel_and_doors();
      test_emergency_stops();
      test_zero_timers();
      test_range_limits();
      test_queue_full();
      test_backpressure();
      test_random_traffic();
      test_longest_move();

      req_valid <= 1'b0;
      while (expected_car_words.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d words (%0d floor calls), checked %0d results, %0d register writes",
               words_sent, calls_sent, results_checked, reg_writes);
      $display("Calls accepted %0d, out of range %0d, ring full %0d; %0d door openings, %0d %s",
               status_seen[RS_ACCEPT], status_seen[RS_RANGE], status_seen[RS_FULL],
               door_opens, obstacle_holds, "obstacle holds");
      if (mismatch_count == 0 && expected_car_words.size() == 0)
         $display("elevator_fifo_controller: match");
      else
         $display("elevator_fifo_controller: mismatch");
      $finish;
   end

endmodule

[elevator_fifo_controller.f]
+incdir+hw/rtl
hw/rtl/efc_pkg.sv
hw/rtl/efc_csr.sv
hw/rtl/efc_front.sv
hw/rtl/efc_cmdq.sv
hw/rtl/efc_back.sv
hw/rtl/elevator_fifo_controller.sv
tb/sv/elevator_fifo_controller_tb.sv
